>>> rtl/mcfir_pkg.sv
// Shared types and constants for the multichannel FIR filter unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcfir_pkg;

  // Default configuration of the block.
  localparam int DEF_TAP_COUNT     = 64;
  localparam int DEF_CHANNEL_COUNT = 32;
  localparam int DEF_SAMPLE_BITS   = 24;

  // Fixed field widths of the item interface.
  localparam int CHANNEL_W = 5;
  localparam int CINDEX_W  = 6;
  localparam int DATA_W    = 32;

  // Depth of the queue between front end and engine (power of two).
  localparam int QUEUE_DEPTH = 4;

  // Item codes.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [CHANNEL_W-1:0] channel;
    logic                 frame_end;
    logic [CINDEX_W-1:0]  coeff_index;
  } mcfir_ctl_t;

  // One queued item: control part plus coefficient or sign-extended sample.
  typedef struct packed {
    mcfir_ctl_t          ctl;
    logic [DATA_W-1:0]   data;
  } mcfir_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_MAG,
    ST_SCALE,
    ST_OUT
  } mcfir_state_t;

endpackage

>>> rtl/mcfir_front.sv
// Input front end: transfer handshake and item classification.
// Depends on mcfir_pkg; feeds mcfir_queue.
`timescale 1ns / 1ps

module mcfir_front import mcfir_pkg::*; #(
  parameter int TAP_COUNT     = DEF_TAP_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode,
  input  logic [CHANNEL_W-1:0]          channel,
  input  logic                          frame_end,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CINDEX_W-1:0]           coeff_index,
  input  logic signed [DATA_W-1:0]      coeff_value,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          q_push,
  output mcfir_entry_t                  q_entry
);

  logic accept;
  logic keep;

  assign full   = q_full || clearing;
  assign accept = push && !full;

  // Out-of-range taps and channels are dropped here and never reach the engine.
  always_comb begin
    if (opcode == OP_LOAD) begin
      keep = 32'(coeff_index) < 32'(TAP_COUNT);
    end else begin
      keep = 32'(channel) < 32'(CHANNEL_COUNT);
    end
  end

  assign q_push = accept && keep;

  always_comb begin
    q_entry.ctl.op          = opcode;
    q_entry.ctl.channel     = channel;
    q_entry.ctl.frame_end   = frame_end;
    q_entry.ctl.coeff_index = coeff_index;
    if (opcode == OP_LOAD) begin
      q_entry.data = coeff_value;
    end else begin
      q_entry.data = DATA_W'(sample);
    end
  end

endmodule

>>> rtl/mcfir_queue.sv
// Short FIFO that decouples the front end from the filter engine.
// Depends on mcfir_pkg (entry type, depth).
`timescale 1ns / 1ps

module mcfir_queue import mcfir_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mcfir_entry_t wdata,
  output logic         full,
  input  logic         take,
  output mcfir_entry_t head,
  output logic         empty
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  mcfir_entry_t     slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QAW:0]     count;

  assign full  = count == (QAW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mcfir_engine.sv
// Filter engine: coefficient and delay memories, shared MAC, rounding,
// saturation and the result register. Depends on mcfir_pkg.
`timescale 1ns / 1ps

module mcfir_engine import mcfir_pkg::*; #(
  parameter int TAP_COUNT     = DEF_TAP_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  mcfir_entry_t            q_head,
  output logic                    q_take,
  output logic                    clearing,
  output logic                    empty,
  input  logic                    pop,
  output logic [CHANNEL_W-1:0]    out_channel,
  output logic signed [31:0]      filtered,
  output logic                    saturated
);

  localparam int DEPTH = CHANNEL_COUNT * TAP_COUNT;
  localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAW   = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PW    = SAMPLE_BITS + 32;
  localparam int AW    = PW + TAW;

  localparam logic [TAW-1:0] TAP_LAST = TAW'(TAP_COUNT - 1);
  localparam logic [DAW-1:0] CLR_LAST = DAW'(DEPTH - 1);

  mcfir_state_t state, state_next;

  // Memories
  logic signed [SAMPLE_BITS-1:0] delay_mem [DEPTH];
  logic signed [31:0]            coeff_mem [TAP_COUNT];

  // Control state
  logic [DAW-1:0]   clr_cnt;
  logic [TAW-1:0]   slot;
  logic             v1;
  logic             v2;
  logic             out_valid;

  // Item and datapath registers
  logic [CHANNEL_W-1:0]          ch;
  logic                          fend;
  logic [SAMPLE_BITS-1:0]        samp;
  logic [DAW-1:0]                base;
  logic [TAW-1:0]                tap;
  logic [TAW-1:0]                idx;
  logic signed [SAMPLE_BITS-1:0] d_rd;
  logic signed [31:0]            c_rd;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          acc;
  logic [AW-1:0]                 mag;
  logic                          neg;
  logic [AW-1:0]                 q;

  // Combinational controls
  logic                   dw_en;
  logic [DAW-1:0]         dw_addr;
  logic [SAMPLE_BITS-1:0] dw_data;
  logic                   cw_en;
  logic [TAW-1:0]         cw_addr;
  logic [31:0]            cw_data;
  logic                   issue;
  logic [DAW-1:0]         d_raddr;
  logic                   out_load;
  logic                   sat_pos;
  logic                   sat_neg;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (!q_empty && q_head.ctl.op == OP_FILTER) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_MAC;
      ST_MAC:   if (tap == TAP_LAST) state_next = ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_MAG;
      ST_MAG:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_take   = 1'b0;
    clearing = 1'b0;
    dw_en    = 1'b0;
    dw_addr  = base + DAW'(slot);
    dw_data  = samp;
    cw_en    = 1'b0;
    cw_addr  = TAW'(q_head.ctl.coeff_index);
    cw_data  = q_head.data;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        dw_en    = 1'b1;
        dw_addr  = clr_cnt;
        dw_data  = '0;
        cw_en    = 32'(clr_cnt) < 32'(TAP_COUNT);
        cw_addr  = clr_cnt[TAW-1:0];
        cw_data  = '0;
      end
      ST_IDLE: begin
        q_take = !q_empty;
        cw_en  = !q_empty && q_head.ctl.op == OP_LOAD;
      end
      ST_WRITE: dw_en = 1'b1;
      ST_MAC:   issue = 1'b1;
      ST_OUT:   out_load = !out_valid || pop;
      default: ;
    endcase
  end

  assign d_raddr = base + DAW'(idx);

  always_ff @(posedge clk) begin
    if (dw_en) begin
      delay_mem[dw_addr] <= dw_data;
    end
    d_rd <= delay_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      coeff_mem[cw_addr] <= cw_data;
    end
    c_rd <= coeff_mem[tap];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      slot      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_WRITE && fend) begin
        slot <= (slot == TAP_LAST) ? '0 : slot + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Saturation decision on the scaled magnitude
  assign sat_pos = !neg && (q > AW'(64'h7FFF_FFFF));
  assign sat_neg = neg && (q > AW'(64'h8000_0000));

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_take && q_head.ctl.op == OP_FILTER) begin
      ch   <= q_head.ctl.channel;
      fend <= q_head.ctl.frame_end;
      samp <= q_head.data[SAMPLE_BITS-1:0];
      base <= DAW'(32'(q_head.ctl.channel) * 32'(TAP_COUNT));
    end
    if (state == ST_WRITE) begin
      tap <= '0;
      idx <= (slot == TAP_LAST) ? '0 : slot + 1'b1;
      acc <= '0;
    end
    if (issue) begin
      tap <= tap + 1'b1;
      idx <= (idx == TAP_LAST) ? '0 : idx + 1'b1;
    end
    if (v1) begin
      prod <= d_rd * c_rd;
    end
    if (v2) begin
      acc <= acc + AW'(prod);
    end
    if (state == ST_MAG) begin
      neg <= acc[AW-1];
      mag <= acc[AW-1] ? (~acc + 1'b1) : acc;
    end
    if (state == ST_SCALE) begin
      q <= (mag + AW'(64'h2000_0000)) >> 30;
    end
    if (out_load) begin
      out_channel <= ch;
      saturated   <= sat_pos || sat_neg;
      if (sat_pos) begin
        filtered <= 32'sh7FFF_FFFF;
      end else if (sat_neg) begin
        filtered <= 32'sh8000_0000;
      end else if (neg) begin
        filtered <= -q[31:0];
      end else begin
        filtered <= q[31:0];
      end
    end
  end

  assign empty = !out_valid;

endmodule

>>> rtl/multichannel_fir_filter_unit.sv
// Top level of the multichannel FIR filter unit.
// Depends on mcfir_pkg, mcfir_front, mcfir_queue and mcfir_engine.
`timescale 1ns / 1ps

// Multichannel FIR filter: CHANNEL_COUNT channels share one set of TAP_COUNT
// Q2.30 coefficients, each channel keeping its own circular delay line at a
// common write slot that steps after a sample item with frame_end set. Items
// are pushed into a 4-deep queue; a load item writes one coefficient and
// gives no result, a sample item is computed by the single shared
// multiply-accumulate that walks the taps one per cycle through the delay and
// coefficient memories. Items with an out-of-range channel or tap are dropped
// at the input and never occupy the engine. After reset a clearing pass zeroes
// both memories across all CHANNEL_COUNT * TAP_COUNT delay addresses; full
// stays high meanwhile. Results wait in an output register, so the engine
// works on the next queued item while a result is not yet popped, but holds
// its own result in ST_OUT until the output register is free.
module multichannel_fir_filter_unit import mcfir_pkg::*; #(
  parameter int TAP_COUNT     = DEF_TAP_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item transfer
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode,
  input  logic [CHANNEL_W-1:0]          channel,
  input  logic                          frame_end,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CINDEX_W-1:0]           coeff_index,
  input  logic signed [DATA_W-1:0]      coeff_value,
  // result transfer
  output logic                          empty,
  input  logic                          pop,
  output logic [CHANNEL_W-1:0]          out_channel,
  output logic signed [31:0]            filtered,
  output logic                          saturated
);

  // Front end to queue
  logic         q_push;
  mcfir_entry_t q_entry;
  logic         q_full;
  // Queue to engine
  logic         q_take;
  logic         q_empty;
  mcfir_entry_t q_head;
  // Engine busy with the post-reset clearing pass
  logic         eng_clearing;

  mcfir_front #(
    .TAP_COUNT     (TAP_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .channel     (channel),
    .frame_end   (frame_end),
    .sample      (sample),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .clearing    (eng_clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  mcfir_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_entry),
    .full  (q_full),
    .take  (q_take),
    .head  (q_head),
    .empty (q_empty)
  );

  // Back end: memories, MAC loop, rounding and the result register.
  mcfir_engine #(
    .TAP_COUNT     (TAP_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_take      (q_take),
    .clearing    (eng_clearing),
    .empty       (empty),
    .pop         (pop),
    .out_channel (out_channel),
    .filtered    (filtered),
    .saturated   (saturated)
  );

`ifndef ASSERT_OFF
  // The front end must never write into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The engine only takes items that are present.
  a_no_take_empty: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !q_empty)
    else $error("queue read while empty");

  // No input transfer is taken during the clearing pass.
  a_hold_clear: assert property (@(posedge clk) disable iff (rst)
    eng_clearing |-> full)
    else $error("input open during clearing pass");

  // Nothing is taken from the queue while the clearing pass runs.
  a_queue_idle_clear: assert property (@(posedge clk) disable iff (rst)
    eng_clearing |-> !q_take)
    else $error("engine took an item while clearing");
`endif

endmodule
